@@ rtl/pir_pkg.sv @@
// ----------------------------------------------------------------------------
// pir_pkg: shared types and constants for the periodic image replicator
// Field widths, register indexes, per-atom metadata and the image order table.
// ----------------------------------------------------------------------------
`default_nettype none

package pir_pkg;

  // Default parameter values
  localparam int MAX_LABELS_DEF  = 4;
  localparam int COORD_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int LABEL_SLOTS = 4;
  localparam int LABEL_W     = 8;
  localparam int LCOUNT_W    = 3;
  localparam int CELL_W      = 31;
  localparam int TYPE_W      = 8;
  localparam int MOL_W       = 16;
  localparam int TIDX_W      = 2;
  localparam int CODE_W      = 3;
  localparam int NUM_IMAGES  = 8;
  localparam int IMG_IDX_W   = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE        = 3'd0,
    REG_CELL_X      = 3'd1,
    REG_CELL_Y      = 3'd2,
    REG_CELL_Z      = 3'd3,
    REG_LABEL_COUNT = 3'd4,
    REG_LABEL_TABLE = 3'd5
  } cfg_reg_t;

  // Operating modes
  localparam logic MODE_FILTER   = 1'b0;
  localparam logic MODE_KEEP_ALL = 1'b1;

  // Per-atom data that is fixed for all of its images
  typedef struct packed {
    logic [TIDX_W-1:0] tidx;
    logic [MOL_W-1:0]  midx;
    logic [MOL_W-1:0]  mol;
    logic [CODE_W-1:0] signs;   // bit set: reference coordinate negative
  } atom_meta_t;

  // Image code for each emission slot: 0,1,2,4,3,5,6,7
  function automatic logic [CODE_W-1:0] image_order(input logic [IMG_IDX_W-1:0] k);
    logic [CODE_W-1:0] code;
    case (k)
      3'd3:    code = 3'd4;
      3'd4:    code = 3'd3;
      default: code = k;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

@@ rtl/periodic_image_replicator.sv @@
// ----------------------------------------------------------------------------
// periodic_image_replicator: emit each kept atom with its seven periodic images
// Filters atoms by type label, numbers molecules densely, and shifts the
// coordinates by the cell lengths with saturation.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | input     | in_valid/in_ready  | pos_x/y/z, atom_type, molecule_number
//  out     | output    | out_valid/out_ready| out_x/y/z, type_index, molecule_index,
//          |           |                    | molecule_original, image_code, last
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
//  A kept atom produces eight words, one per cycle while the output is not
//  stalled, set by the image counter that walks the held atom register. An
//  atom is taken while the previous one's final image moves to the output
//  register; a filtered-out atom is accepted and dropped without any words.
//  Synchronous reset clears config, molecule state and all valid flags.
//  A stalled output holds the output register and the image counter.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_image_replicator
  import pir_pkg::*;
#(
  parameter int MAX_LABELS  = MAX_LABELS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] pos_x,
  input  wire logic signed [COORD_WIDTH-1:0] pos_y,
  input  wire logic signed [COORD_WIDTH-1:0] pos_z,
  input  wire logic [TYPE_W-1:0]             atom_type,
  input  wire logic [MOL_W-1:0]              molecule_number,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0]      out_x,
  output logic signed [COORD_WIDTH-1:0]      out_y,
  output logic signed [COORD_WIDTH-1:0]      out_z,
  output logic [TIDX_W-1:0]                  type_index,
  output logic [MOL_W-1:0]                   molecule_index,
  output logic [MOL_W-1:0]                   molecule_original,
  output logic [CODE_W-1:0]                  image_code,
  output logic                               last
);

  localparam int EFF_SLOTS = (MAX_LABELS < LABEL_SLOTS) ? MAX_LABELS : LABEL_SLOTS;
  localparam int SUM_W     = ((COORD_WIDTH > CELL_W) ? COORD_WIDTH : CELL_W) + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  // Configuration registers
  logic                          mode;
  logic [CELL_W-1:0]             cell_x;
  logic [CELL_W-1:0]             cell_y;
  logic [CELL_W-1:0]             cell_z;
  logic [LCOUNT_W-1:0]           label_count;
  logic [LABEL_SLOTS*LABEL_W-1:0] label_table;

  // Molecule tracking state
  logic              ref_valid;
  logic [MOL_W-1:0]  ref_molecule;
  logic [CODE_W-1:0] ref_signs;
  logic [MOL_W-1:0]  molecule_count;

  // Held atom
  logic                          atom_valid;
  logic signed [COORD_WIDTH-1:0] atom_x;
  logic signed [COORD_WIDTH-1:0] atom_y;
  logic signed [COORD_WIDTH-1:0] atom_z;
  atom_meta_t                    atom_meta;
  atom_meta_t                    atom_meta_next;
  logic [IMG_IDX_W-1:0]          img_idx;

  logic              in_take;
  logic              keep;
  logic [TIDX_W-1:0] hit_idx;
  logic              new_mol;
  logic [CODE_W-1:0] in_signs;
  logic              advance;
  logic              final_img;
  logic [CODE_W-1:0] code;
  logic signed [COORD_WIDTH-1:0] img_x;
  logic signed [COORD_WIDTH-1:0] img_y;
  logic signed [COORD_WIDTH-1:0] img_z;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_FILTER;
      cell_x      <= '0;
      cell_y      <= '0;
      cell_z      <= '0;
      label_count <= '0;
      label_table <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODE:        mode        <= cfg_data[0];
        REG_CELL_X:      cell_x      <= cfg_data[CELL_W-1:0];
        REG_CELL_Y:      cell_y      <= cfg_data[CELL_W-1:0];
        REG_CELL_Z:      cell_z      <= cfg_data[CELL_W-1:0];
        REG_LABEL_COUNT: label_count <= cfg_data[LCOUNT_W-1:0];
        REG_LABEL_TABLE: label_table <= cfg_data[LABEL_SLOTS*LABEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Match the type against the active labels, first hit wins
  always_comb begin
    logic hit;
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < LABEL_SLOTS; i++) begin
      if (!hit && (i < EFF_SLOTS) && (LCOUNT_W'(i) < label_count) &&
          (label_table[i*LABEL_W +: LABEL_W] == atom_type)) begin
        hit     = 1'b1;
        hit_idx = TIDX_W'(i);
      end
    end
    keep = (mode == MODE_KEEP_ALL) || hit;
  end

  // Molecule numbering and reference signs for the incoming atom
  always_comb begin
    new_mol  = !ref_valid || (ref_molecule != molecule_number);
    in_signs = {pos_z[COORD_WIDTH-1], pos_y[COORD_WIDTH-1], pos_x[COORD_WIDTH-1]};
    atom_meta_next.tidx  = (mode == MODE_KEEP_ALL) ? '0 : hit_idx;
    atom_meta_next.mol   = molecule_number;
    atom_meta_next.signs = new_mol ? in_signs : ref_signs;
    atom_meta_next.midx  = new_mol ? molecule_count : molecule_count - MOL_W'(1);
  end

  // Output register loads when empty or being drained
  assign advance   = atom_valid && (!out_valid || out_ready);
  assign final_img = (img_idx == IMG_IDX_W'(NUM_IMAGES - 1));
  assign in_ready  = !atom_valid || (advance && final_img);
  assign in_take   = in_valid && in_ready;

  // Update molecule state on each kept atom
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_valid      <= 1'b0;
      ref_molecule   <= '0;
      ref_signs      <= '0;
      molecule_count <= '0;
    end else if (in_take && keep) begin
      ref_valid    <= 1'b1;
      ref_molecule <= molecule_number;
      ref_signs    <= atom_meta_next.signs;
      if (new_mol) begin
        molecule_count <= molecule_count + MOL_W'(1);
      end
    end
  end

  // Hold the atom and walk its images
  always_ff @(posedge clk) begin
    if (rst) begin
      atom_valid <= 1'b0;
      img_idx    <= '0;
    end else if (in_take) begin
      atom_valid <= keep;
      img_idx    <= '0;
    end else if (advance) begin
      atom_valid <= !final_img;
      img_idx    <= img_idx + IMG_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      atom_x    <= pos_x;
      atom_y    <= pos_y;
      atom_z    <= pos_z;
      atom_meta <= atom_meta_next;
    end
  end

  // Shift one axis by its cell length and saturate
  function automatic logic signed [COORD_WIDTH-1:0] shift_axis(
    input logic signed [COORD_WIDTH-1:0] p,
    input logic [CELL_W-1:0]             cell_len,
    input logic                          sel,
    input logic                          neg_ref
  );
    logic signed [SUM_W-1:0] pw;
    logic signed [SUM_W-1:0] cw;
    logic signed [SUM_W-1:0] sum;
    logic signed [COORD_WIDTH-1:0] res;
    pw  = SUM_W'(p);
    cw  = $signed({{(SUM_W-CELL_W){1'b0}}, cell_len});
    sum = neg_ref ? pw + cw : pw - cw;
    if (!sel) begin
      res = p;
    end else if (sum > SAT_HI) begin
      res = SAT_HI[COORD_WIDTH-1:0];
    end else if (sum < SAT_LO) begin
      res = SAT_LO[COORD_WIDTH-1:0];
    end else begin
      res = sum[COORD_WIDTH-1:0];
    end
    return res;
  endfunction

  // Form the current image
  always_comb begin
    code  = image_order(img_idx);
    img_x = shift_axis(atom_x, cell_x, code[0], atom_meta.signs[0]);
    img_y = shift_axis(atom_y, cell_y, code[1], atom_meta.signs[1]);
    img_z = shift_axis(atom_z, cell_z, code[2], atom_meta.signs[2]);
  end

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (advance) begin
      out_x             <= img_x;
      out_y             <= img_y;
      out_z             <= img_z;
      type_index        <= atom_meta.tidx;
      molecule_index    <= atom_meta.midx;
      molecule_original <= atom_meta.mol;
      image_code        <= code;
      last              <= final_img;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pir_checker.sv @@
// ----------------------------------------------------------------------------
// pir_checker: port-level checks for the periodic image replicator
// Watches the output channel for ordering and handshake consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module pir_checker
  import pir_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic signed [COORD_WIDTH-1:0] out_x,
  input wire logic [MOL_W-1:0]              molecule_index,
  input wire logic [CODE_W-1:0]             image_code,
  input wire logic                          last
);

  // Drop output valid after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Hold a stalled word
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(image_code))
    else $error("stalled output word changed");

  // Final image of an atom carries all three shifts
  a_last_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> image_code == 3'd7)
    else $error("last flag on wrong image");

  // Images of one atom follow without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("gap inside an atom's images");

  // Molecule index stays fixed across one atom's images
  a_same_mol: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> $stable(molecule_index))
    else $error("molecule index changed inside an atom");

endmodule

bind periodic_image_replicator pir_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pir_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_x          (out_x),
  .molecule_index (molecule_index),
  .image_code     (image_code),
  .last           (last)
);

`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for periodic_image_replicator
// Drives atoms through the valid/ready input and predicts the eight image
// words of every kept atom: label filter, dense molecule numbering,
// reference signs and saturated cell shifts. A scoreboard class compares
// every output word field by field. Both sides idle at random, and one long
// output stall backs the block up into its input.
// ----------------------------------------------------------------------------

module tb;
  import pir_pkg::*;

  localparam int  CYCLE_LIMIT   = 400000;
  localparam int  SETTLE_CYCLES = 16;
  localparam int  HOLD_CYCLES   = 300;
  localparam int  REPORT_CAP    = 60;
  localparam int  PHASE_KEPT    = 34;
  localparam longint COORD_MAX  = 64'sd2147483647;
  localparam longint COORD_MIN  = -64'sd2147483648;

  // Register indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Emission order of the image codes
  localparam bit [CODE_W-1:0] IMAGE_SEQ [NUM_IMAGES] =
    '{3'd0, 3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd7};

  // One output word
  typedef struct {
    logic signed [31:0] pos [3];
    logic [TIDX_W-1:0]  tidx;
    logic [MOL_W-1:0]   midx;
    logic [MOL_W-1:0]   morig;
    logic [CODE_W-1:0]  code;
    logic               last;
  } image_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow registers, molecule tracking and expected image words
  // --------------------------------------------------------------------------
  class image_scoreboard;
    bit                 op_mode;
    bit [CELL_W-1:0]    cell_len [3];
    bit [LCOUNT_W-1:0]  n_labels;
    bit [31:0]          labels;
    bit                 have_mol;
    bit [MOL_W-1:0]     cur_mol;
    bit [2:0]           neg_ref;
    bit [MOL_W-1:0]     mol_total;
    image_word_t        expected_images [$];
    int                 errors;
    int                 atoms_seen;
    int                 atoms_kept;
    int                 images_checked;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MODE:        op_mode = data[0];
        REG_CELL_X:      cell_len[0] = data[CELL_W-1:0];
        REG_CELL_Y:      cell_len[1] = data[CELL_W-1:0];
        REG_CELL_Z:      cell_len[2] = data[CELL_W-1:0];
        REG_LABEL_COUNT: n_labels = data[LCOUNT_W-1:0];
        REG_LABEL_TABLE: labels = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_images.size();
    endfunction

    // Shift one axis by the cell length and clamp to the coordinate range
    function logic signed [31:0] shifted(logic signed [31:0] p, bit [CELL_W-1:0] len,
                                         bit on, bit neg);
      longint s;
      s = p;
      if (on) s = neg ? s + longint'(len) : s - longint'(len);
      if (s > COORD_MAX) s = COORD_MAX;
      if (s < COORD_MIN) s = COORD_MIN;
      return s[31:0];
    endfunction

    // Record an accepted atom and queue its image words
    function void note_atom(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz, logic [TYPE_W-1:0] kind,
                            logic [MOL_W-1:0] mol);
      logic signed [31:0] p [3];
      int                 usable;
      bit                 hit;
      bit [TIDX_W-1:0]    idx;
      image_word_t        w;
      bit [CODE_W-1:0]    code;
      p[0] = px;
      p[1] = py;
      p[2] = pz;
      atoms_seen++;
      idx = '0;
      if (op_mode == MODE_FILTER) begin
        usable = n_labels;
        if (usable > MAX_LABELS_DEF) usable = MAX_LABELS_DEF;
        if (usable > LABEL_SLOTS) usable = LABEL_SLOTS;
        hit = 1'b0;
        for (int i = 0; i < usable; i++) begin
          if (!hit && labels[8*i +: 8] == kind) begin
            hit = 1'b1;
            idx = TIDX_W'(i);
          end
        end
        // drop: no label matches, state stays as it was
        if (!hit) return;
      end
      atoms_kept++;
      // start a new molecule on a changed number
      if (!have_mol || cur_mol != mol) begin
        have_mol  = 1'b1;
        cur_mol   = mol;
        mol_total = mol_total + 1'b1;
        neg_ref   = {p[2] < 0, p[1] < 0, p[0] < 0};
      end
      for (int k = 0; k < NUM_IMAGES; k++) begin
        code = IMAGE_SEQ[k];
        for (int a = 0; a < 3; a++)
          w.pos[a] = shifted(p[a], cell_len[a], code[a], neg_ref[a]);
        w.tidx  = idx;
        w.midx  = mol_total - 1'b1;
        w.morig = cur_mol;
        w.code  = code;
        w.last  = (k == NUM_IMAGES - 1);
        expected_images.push_back(w);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        if (errors < REPORT_CAP)
          $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
        errors++;
      end
    endfunction

    // Compare one output word against the oldest expectation
    function void check_image(image_word_t got);
      image_word_t want;
      if (expected_images.size() == 0) begin
        if (errors < REPORT_CAP)
          $display("%0t: unexpected word, expected none, actual code %h x %h",
                   $time, got.code, got.pos[0]);
        errors++;
        return;
      end
      want = expected_images.pop_front();
      images_checked++;
      compare_field("out_x", want.pos[0], got.pos[0]);
      compare_field("out_y", want.pos[1], got.pos[1]);
      compare_field("out_z", want.pos[2], got.pos[2]);
      compare_field("type_index", want.tidx, got.tidx);
      compare_field("molecule_index", want.midx, got.midx);
      compare_field("molecule_original", want.morig, got.morig);
      compare_field("image_code", want.code, got.code);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [31:0]       pos_x = '0;
  logic signed [31:0]       pos_y = '0;
  logic signed [31:0]       pos_z = '0;
  logic [TYPE_W-1:0]        atom_type = '0;
  logic [MOL_W-1:0]         molecule_number = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [31:0]       out_x;
  logic signed [31:0]       out_y;
  logic signed [31:0]       out_z;
  logic [TIDX_W-1:0]        type_index;
  logic [MOL_W-1:0]         molecule_index;
  logic [MOL_W-1:0]         molecule_original;
  logic [CODE_W-1:0]        image_code;
  logic                     last;

  image_scoreboard sb = new();
  image_word_t     seen_word;
  bit              hold_request = 1'b0;
  int              cycle_count = 0;
  int              configs = 0;

  periodic_image_replicator dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .pos_x             (pos_x),
    .pos_y             (pos_y),
    .pos_z             (pos_z),
    .atom_type         (atom_type),
    .molecule_number   (molecule_number),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_z             (out_z),
    .type_index        (type_index),
    .molecule_index    (molecule_index),
    .molecule_original (molecule_original),
    .image_code        (image_code),
    .last              (last)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still expected",
               cycle_count, sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Watch both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_atom(pos_x, pos_y, pos_z, atom_type, molecule_number);
      if (out_valid && out_ready) begin
        seen_word.pos[0] = out_x;
        seen_word.pos[1] = out_y;
        seen_word.pos[2] = out_z;
        seen_word.tidx   = type_index;
        seen_word.midx   = molecule_index;
        seen_word.morig  = molecule_original;
        seen_word.code   = image_code;
        seen_word.last   = last;
        sb.check_image(seen_word);
      end
    end
  end

  // Receiver: alternate ready and stall runs, plus one long hold on request
  initial begin : receiver
    int run_left;
    int hold_left;
    bit level;
    run_left  = 0;
    hold_left = 0;
    level     = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          level = ~level;
          if (level)
            run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 10);
          else
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                   : $urandom_range(1, 3);
        end
        run_left--;
        out_ready <= level;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks and stimulus helpers
  // --------------------------------------------------------------------------

  // Write one register; the enable stays high for back-to-back writes
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Load every register, with junk in the unused bits and the spare indexes
  task automatic apply_config(logic m, logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [LCOUNT_W-1:0] lc, logic [31:0] lt);
    logic [31:0] junk;
    junk = $urandom;
    cfg_write(REG_MODE, {junk[31:1], m});
    cfg_write(REG_CELL_X, cx);
    cfg_write(REG_CELL_Y, cy);
    cfg_write(REG_CELL_Z, cz);
    junk = $urandom;
    cfg_write(REG_LABEL_COUNT, {junk[31:LCOUNT_W], lc});
    cfg_write(REG_LABEL_TABLE, lt);
    cfg_write(REG_SPARE_LO, $urandom);
    cfg_write(REG_SPARE_HI, $urandom);
    cfg_we <= 1'b0;
    configs++;
  endtask

  // Offer one atom and hold it until taken; drop valid only before a gap
  task automatic send_atom(logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z, logic [TYPE_W-1:0] kind,
                           logic [MOL_W-1:0] mol, int gap);
    in_valid        <= 1'b1;
    pos_x           <= x;
    pos_y           <= y;
    pos_z           <= z;
    atom_type       <= kind;
    molecule_number <= mol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering, wait for every expected word, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] rand_coord();
    logic signed [31:0] v;
    logic [23:0]        off;
    off = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = $urandom_range(0, 1) ? $signed({8'h00, off}) : -$signed({8'h00, off});
      7:          v = 32'sh7FFF_FFFF - off;
      8:          v = 32'sh8000_0000 + off;
      default:    v = $urandom_range(0, 2) - 1;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_cell();
    logic [CELL_W-1:0] c;
    bit                top;
    top = $urandom_range(0, 1);
    case ($urandom_range(0, 7))
      0:       c = '0;
      1:       c = '1;
      2, 3:    c = $urandom;
      default: c = $urandom_range(1, 32'h0040_0000);
    endcase
    return {top, c};
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic                m;
    logic [LCOUNT_W-1:0] lc;
    logic [31:0]         lt;
    int                  usable;
    int                  goal;
    int                  run_len;
    int                  burst;
    logic [MOL_W-1:0]    mol;
    logic [MOL_W-1:0]    mol_last;
    logic [MOL_W-1:0]    mol_prev;
    logic [TYPE_W-1:0]   kind;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Filter on three labels, slot 1 and 2 equal, slot 3 out of range
    apply_config(MODE_FILTER, 32'h000A_0000, 32'h7FFF_FFFF, 32'h0, 3'd3,
                 {8'hFF, 8'h07, 8'h07, 8'h00});
    send_atom(-32'sh0001_0000, 32'sh0002_0000, 32'sh0, 8'h00, 16'd3, rand_gap());
    // same molecule, opposite signs: saturate on x and y
    send_atom(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 8'h07, 16'd3, rand_gap());
    // no match leaves the molecule state alone
    send_atom(rand_coord(), rand_coord(), rand_coord(), 8'hFF, 16'd9, rand_gap());
    send_atom(rand_coord(), rand_coord(), rand_coord(), 8'h42, 16'd9, rand_gap());
    send_atom(32'sh8000_0000, 32'sh0000_0001, -32'sh1, 8'h07, 16'd3, rand_gap());
    send_atom(32'sh0, -32'sh1, 32'sh8000_0000, 8'h00, 16'd4, rand_gap());
    // return to an earlier number: new index
    send_atom(rand_coord(), rand_coord(), rand_coord(), 8'h00, 16'd3, rand_gap());
    send_atom(rand_coord(), rand_coord(), rand_coord(), 8'h07, 16'hFFFF, rand_gap());
    drain_results();

    // Oversized label count, all four slots live, zero cells
    apply_config(MODE_FILTER, 32'h0, 32'h0, 32'h0, 3'd7, {8'hAB, 8'h34, 8'h12, 8'h56});
    send_atom(rand_coord(), rand_coord(), rand_coord(), 8'hAB, 16'd0, rand_gap());
    send_atom(rand_coord(), rand_coord(), rand_coord(), 8'h56, 16'd0, rand_gap());
    send_atom(rand_coord(), rand_coord(), rand_coord(), 8'h99, 16'd1, rand_gap());
    drain_results();

    // No labels: every atom is dropped
    apply_config(MODE_FILTER, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 3'd0,
                 {8'hAB, 8'h34, 8'h12, 8'h56});
    send_atom(rand_coord(), rand_coord(), rand_coord(), 8'h56, 16'd7, rand_gap());
    send_atom(rand_coord(), rand_coord(), rand_coord(), 8'h00, 16'd7, rand_gap());
    drain_results();

    // Keep all with the largest cells
    apply_config(MODE_KEEP_ALL, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 3'd1, 32'h0);
    send_atom(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, 8'h5A, 16'hFFFF, rand_gap());
    send_atom(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 8'hC3, 16'hFFFF, rand_gap());
    send_atom(32'sh1, -32'sh1, 32'sh7FFF_FFFF, 8'h00, 16'd0, rand_gap());
    send_atom(-32'sh1, 32'sh1, 32'sh8000_0000, 8'hFF, 16'd0, rand_gap());
    send_atom(rand_coord(), rand_coord(), rand_coord(), $urandom, 16'h8000, rand_gap());
    drain_results();

    // Random phases: molecules as runs of atoms, mostly matching labels
    mol_last = $urandom;
    mol_prev = $urandom;
    for (int phase = 0; phase < 5; phase++) begin
      m  = (phase == 3) ? MODE_KEEP_ALL : (phase == 4) ? $urandom_range(0, 1) : MODE_FILTER;
      lc = $urandom_range(1, 7);
      lt = $urandom;
      if ($urandom_range(0, 3) == 0) lt[15:8] = lt[7:0];
      apply_config(m, pick_cell(), pick_cell(), pick_cell(), lc, lt);
      usable = (lc > LABEL_SLOTS) ? LABEL_SLOTS : lc;
      goal   = sb.atoms_kept + PHASE_KEPT;
      burst  = 0;
      // back the block up against a long output stall
      if (phase == 2) begin
        hold_request = 1'b1;
        burst        = 30;
      end
      while (sb.atoms_kept < goal) begin
        case ($urandom_range(0, 6))
          0:       mol = mol_prev;
          1:       mol = mol_last;
          default: mol = $urandom;
        endcase
        if (mol != mol_last) begin
          mol_prev = mol_last;
          mol_last = mol;
        end
        run_len = $urandom_range(1, 6);
        repeat (run_len) begin
          if ($urandom_range(0, 9) < 8) kind = lt[8*$urandom_range(0, usable - 1) +: 8];
          else kind = $urandom;
          send_atom(rand_coord(), rand_coord(), rand_coord(), kind, mol,
                    (burst > 0) ? 0 : rand_gap());
          if (burst > 0) burst--;
        end
      end
      drain_results();
    end

    $display("Run covered %0d atoms offered, %0d kept, %0d image words checked",
             sb.atoms_seen, sb.atoms_kept, sb.images_checked);
    $display("over %0d register settings in both modes, with random and long output stalls",
             configs);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d words never seen", sb.errors, sb.pending());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/pir_pkg.sv
rtl/periodic_image_replicator.sv
rtl/pir_checker.sv
test/tb.sv
